FILE: rtl/core/xtea_cipher_byte_key_defines.svh
// Assertion macros used by the cipher top-level module.
`ifndef XTEA_CIPHER_BYTE_KEY_DEFINES_SVH
`define XTEA_CIPHER_BYTE_KEY_DEFINES_SVH

// Checks that a condition implies a consequence on the following clock edge.
`define XTEABK_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
	else $error("cipher pipeline check failed");

// Checks that a condition implies a consequence on the same clock edge.
`define XTEABK_ASSERT_NOW(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
	else $error("cipher pipeline check failed");

`endif

FILE: rtl/core/xteabk_pkg.sv
package xteabk_pkg;

	localparam logic [31:0] DELTA = 32'h9E37_79B9;

	typedef enum logic {
		DIR_ENC = 1'b0,
		DIR_DEC = 1'b1
	} dir_t;

	typedef enum logic [1:0] {
		REG_KEY_BYTES = 2'd0,
		REG_DIRECTION = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
	} blk_t;

	function automatic logic [31:0] mix(input logic [31:0] w);
		return ((w << 4) ^ (w >> 5)) + w;
	endfunction

endpackage

FILE: rtl/core/xteabk_ifs.sv
interface xteabk_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_word;
	logic [31:0] second_word;

	modport source (output valid, output first_word, output second_word, input ready);
	modport sink (input valid, input first_word, input second_word, output ready);
endinterface

interface xteabk_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_out;
	logic [31:0] second_out;

	modport source (output valid, output first_out, output second_out, input ready);
	modport sink (input valid, input first_out, input second_out, output ready);
endinterface

FILE: rtl/core/xtea_cipher_byte_key.sv
// Each stage holds one half-round, one adder chain deep.
// Throughput: one word per cycle unless the result at the output is waiting.
// The whole pipeline holds while the result at the output waits to be taken.
// Reset clears every stage's valid bit, sets the key to zero and selects decipher.
module xtea_cipher_byte_key
	import xteabk_pkg::*;
#(
	parameter int unsigned ROUNDS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	xteabk_in_if.sink           blk_in,
	xteabk_out_if.source        blk_out
);

	`include "xtea_cipher_byte_key_defines.svh"

	localparam int unsigned NSTAGE = 2 * ROUNDS;

	logic [31:0]       key_bytes_q;
	dir_t              direction_q;
	logic              advance;
	blk_t              head_blk;
	logic [NSTAGE-1:0] pipe_valid_s;
	blk_t              pipe_blk_s [NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q <= 32'd0;
			direction_q <= DIR_DEC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_BYTES: key_bytes_q <= cfg_wdata;
				REG_DIRECTION: direction_q <= dir_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	assign advance        = !pipe_valid_s[NSTAGE-1] || blk_out.ready;
	assign blk_in.ready   = advance;
	assign head_blk.v0    = blk_in.first_word;
	assign head_blk.v1    = blk_in.second_word;

	for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
		if (j == 0) begin : g_head
			xteabk_half_round #(
				.ROUNDS(ROUNDS),
				.STAGE (j)
			) u_half (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (advance),
				.key_bytes(key_bytes_q),
				.direction(direction_q),
				.in_valid (blk_in.valid),
				.in_blk   (head_blk),
				.out_valid(pipe_valid_s[j]),
				.out_blk  (pipe_blk_s[j])
			);
		end else begin : g_body
			xteabk_half_round #(
				.ROUNDS(ROUNDS),
				.STAGE (j)
			) u_half (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (advance),
				.key_bytes(key_bytes_q),
				.direction(direction_q),
				.in_valid (pipe_valid_s[j-1]),
				.in_blk   (pipe_blk_s[j-1]),
				.out_valid(pipe_valid_s[j]),
				.out_blk  (pipe_blk_s[j])
			);
		end
	end

	assign blk_out.valid      = pipe_valid_s[NSTAGE-1];
	assign blk_out.first_out  = pipe_blk_s[NSTAGE-1].v0;
	assign blk_out.second_out = pipe_blk_s[NSTAGE-1].v1;

	`XTEABK_ASSERT_NEXT(a_head_load, arst_n && advance, pipe_valid_s[0] == $past(blk_in.valid))
	`XTEABK_ASSERT_NEXT(a_hold_on_stall, arst_n && !advance, $stable(pipe_valid_s))
	`XTEABK_ASSERT_NEXT(a_shift, arst_n && advance, pipe_valid_s[NSTAGE-1:1] == $past(pipe_valid_s[NSTAGE-2:0]))
	`XTEABK_ASSERT_NOW(a_no_drop, pipe_valid_s[NSTAGE-1] && !blk_out.ready, !blk_in.ready)

endmodule

FILE: rtl/core/xteabk_half_round.sv
module xteabk_half_round
	import xteabk_pkg::*;
#(
	parameter int unsigned ROUNDS = 32,
	parameter int unsigned STAGE  = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [31:0] key_bytes,
	input  dir_t        direction,
	input  logic        in_valid,
	input  blk_t        in_blk,
	output logic        out_valid,
	output blk_t        out_blk
);

	localparam int unsigned ENC_K   = (STAGE + 1) / 2;
	localparam int unsigned DEC_K   = ROUNDS - ENC_K;
	localparam logic [63:0] ENC_P   = 64'(ENC_K) * 64'(DELTA);
	localparam logic [63:0] DEC_P   = 64'(DEC_K) * 64'(DELTA);
	localparam logic [31:0] SUM_ENC = ENC_P[31:0];
	localparam logic [31:0] SUM_DEC = DEC_P[31:0];
	localparam bit          IS_EVEN = (STAGE % 2) == 0;

	logic        upd_v0;
	logic [31:0] sum;
	logic [1:0]  sel;
	logic [7:0]  key_byte;
	logic [31:0] kterm;
	logic [31:0] src;
	logic [31:0] tgt;
	logic [31:0] term;
	logic [31:0] res;
	blk_t        nxt_blk;
	logic        vld_s;
	blk_t        blk_s;

	always_comb begin
		upd_v0   = ((direction == DIR_ENC) == IS_EVEN);
		sum      = (direction == DIR_ENC) ? SUM_ENC : SUM_DEC;
		sel      = upd_v0 ? sum[1:0] : sum[12:11];
		key_byte = key_bytes[{sel, 3'b000} +: 8];
		kterm    = sum + {24'd0, key_byte};
		src      = upd_v0 ? in_blk.v1 : in_blk.v0;
		tgt      = upd_v0 ? in_blk.v0 : in_blk.v1;
		term     = mix(src) ^ kterm;
		res      = (direction == DIR_ENC) ? (tgt + term) : (tgt - term);
		nxt_blk  = in_blk;
		if (upd_v0) begin
			nxt_blk.v0 = res;
		end else begin
			nxt_blk.v1 = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (advance) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blk_s <= nxt_blk;
		end
	end

	assign out_valid = vld_s;
	assign out_blk   = blk_s;

endmodule

FILE: sim/xtea_cipher_byte_key_tb.sv
`timescale 1ns / 100ps

module xtea_cipher_byte_key_tb;
	import xteabk_pkg::*;

	localparam int N_ROUNDS = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;
	localparam int BATCHES = 6;
	localparam int BATCH_WORDS = 100;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int cycle_count = 0;

	xteabk_in_if  blk_in_if ();
	xteabk_out_if blk_out_if ();

	class xtea_scoreboard;
		blk_t        expected_q[$];
		logic [31:0] key;
		dir_t        dir;
		int          errors;

		function new();
			key = 32'h0;
			dir = DIR_DEC;
			errors = 0;
		endfunction

		function void note_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_KEY_BYTES: key = data;
				REG_DIRECTION: dir = dir_t'(data[0]);
				default: ;
			endcase
		endfunction

		function logic [31:0] key_byte(logic [1:0] sel);
			return {24'h0, key[8*sel +: 8]};
		endfunction

		function blk_t cipher_block(logic [31:0] a, logic [31:0] b);
			logic [31:0] y;
			logic [31:0] z;
			logic [31:0] s;
			logic [31:0] f;
			blk_t        res;
			y = a;
			z = b;
			if (dir == DIR_ENC) begin
				s = 32'h0;
				for (int r = 0; r < N_ROUNDS; r++) begin
					f = ((z << 4) ^ (z >> 5)) + z;
					y = y + (f ^ (s + key_byte(s[1:0])));
					s = s + DELTA;
					f = ((y << 4) ^ (y >> 5)) + y;
					z = z + (f ^ (s + key_byte(s[12:11])));
				end
			end else begin
				s = DELTA * N_ROUNDS;
				for (int r = 0; r < N_ROUNDS; r++) begin
					f = ((y << 4) ^ (y >> 5)) + y;
					z = z - (f ^ (s + key_byte(s[12:11])));
					s = s - DELTA;
					f = ((z << 4) ^ (z >> 5)) + z;
					y = y - (f ^ (s + key_byte(s[1:0])));
				end
			end
			res.v0 = y;
			res.v1 = z;
			return res;
		endfunction

		function void note_word(logic [31:0] a, logic [31:0] b);
			expected_q.push_back(cipher_block(a, b));
		endfunction

		function void check_word(logic [31:0] a, logic [31:0] b);
			blk_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: first_out %h second_out %h", a, b);
				return;
			end
			want = expected_q.pop_front();
			if (want.v0 !== a || want.v1 !== b) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: first_out exp %h got %h, second_out exp %h got %h",
						want.v0, a, want.v1, b);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	xtea_scoreboard sb = new();

	xtea_cipher_byte_key u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.blk_in    (blk_in_if),
		.blk_out   (blk_out_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (blk_out_if.valid && blk_out_if.ready)
			sb.check_word(blk_out_if.first_out, blk_out_if.second_out);
		if (recv_hold > 0) begin
			blk_out_if.ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			blk_out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.note_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic send_word(input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_in_if.valid <= 1'b0;
			@(posedge clk);
		end
		blk_in_if.valid <= 1'b1;
		blk_in_if.first_word <= a;
		blk_in_if.second_word <= b;
		@(posedge clk);
		while (!blk_in_if.ready)
			@(posedge clk);
		sb.note_word(a, b);
	endtask

	task automatic wait_idle();
		blk_in_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_config();
		logic [31:0] key;
		case ($urandom_range(7))
			0: key = 32'h0000_0000;
			1: key = 32'hFFFF_FFFF;
			default: key = $urandom;
		endcase
		write_reg(REG_KEY_BYTES, key);
		write_reg(REG_DIRECTION, $urandom);
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_BYTES;
		cfg_wdata = 32'h0;
		blk_in_if.valid = 1'b0;
		blk_in_if.first_word = 32'h0;
		blk_in_if.second_word = 32'h0;
		blk_out_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset key and direction apply until the first write.
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Only bit zero of a direction write counts.
		wait_idle();
		write_reg(REG_KEY_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_DIRECTION, 32'hFFFF_FFFE);
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);

		// Writes to unused indexes must leave the key and direction alone.
		wait_idle();
		write_reg(REG_SPARE_A, 32'h0000_0000);
		write_reg(REG_SPARE_B, 32'h0000_0001);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'h8000_0000, 32'h0000_0001);

		wait_idle();
		write_reg(REG_KEY_BYTES, 32'h0123_4567);
		write_reg(REG_DIRECTION, {31'h0, DIR_DEC});
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'h8000_0000, 32'h0000_0001);

		wait_idle();
		write_reg(REG_DIRECTION, {31'h0, DIR_ENC});
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word(32'h0000_0001, 32'h8000_0000);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int b = 0; b < BATCHES; b++) begin
				wait_idle();
				random_config();
				for (int i = 0; i < BATCH_WORDS; i++) begin
					if (p == 2 && b == 1 && i == 20)
						recv_hold <= LONG_HOLD;
					send_word(pick_word(), pick_word());
				end
			end
		end

		wait_idle();
		repeat (2 * N_ROUNDS + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: xtea_cipher_byte_key.f
+incdir+rtl/core
rtl/core/xteabk_pkg.sv
rtl/core/xteabk_ifs.sv
rtl/core/xteabk_half_round.sv
rtl/core/xtea_cipher_byte_key.sv
sim/xtea_cipher_byte_key_tb.sv
